@@ rtl/bba_pkg.sv @@
// Shared types, codes and defaults for the bitmap block allocator.
package bba_pkg;

  // Fixed field widths of the command and result items.
  localparam int CMD_W  = 2;
  localparam int BLK_W  = 14;
  localparam int CFG_W  = 15;
  localparam int STAT_W = 2;

  // Default sizing of the allocation map.
  localparam int BBA_MAX_BLOCKS = 16384;
  localparam int BBA_WORD_BITS  = 32;

  // Reset value of the total_blocks register.
  localparam logic [CFG_W-1:0] TOTAL_RESET = 15'd16384;

  // Command codes; the unused code behaves as a test.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST  = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MODIFY
  } state_t;

  // Flags from the word scanner back to the controller.
  typedef struct packed {
    logic found;
    logic last;
  } scan_flags_t;

endpackage

@@ rtl/bba_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/bba_word_scan.sv @@
// Finds the first free block of one map word that lies below the block limit.
module bba_word_scan
  import bba_pkg::*;
#(
  parameter int W  = 32,
  parameter int AW = 9,
  parameter int OW = $clog2(W)
) (
  input  logic [W-1:0]     word,
  input  logic [AW-1:0]    word_addr,
  input  logic [CFG_W-1:0] lim,
  output logic [OW-1:0]    pos,
  output scan_flags_t      flags
);

  localparam int BW = AW + OW;
  localparam int XW = ((BW > CFG_W) ? BW : CFG_W) + 1;

  logic [XW-1:0] base;
  logic [XW-1:0] lim_x;
  logic [XW-1:0] rem;
  logic [W-1:0]  range_mask;
  logic [W-1:0]  free_vec;
  logic          hit;

  // Blocks at or beyond the limit count as used.
  always_comb begin
    base  = XW'({word_addr, {OW{1'b0}}});
    lim_x = XW'(lim);
    rem   = lim_x - base;
    if (base >= lim_x) begin
      range_mask = '0;
    end else if (rem >= XW'(W)) begin
      range_mask = '1;
    end else begin
      range_mask = ~({W{1'b1}} >> rem[OW-1:0]);
    end
    free_vec    = ~word & range_mask;
    flags.last  = (base >= lim_x) || (rem <= XW'(W));
    flags.found = |free_vec;
  end

  // Priority encoder: the most significant free bit is the lowest block.
  always_comb begin
    pos = '0;
    hit = 1'b0;
    for (int i = 0; i < W; i++) begin
      if (!hit && free_vec[W-1-i]) begin
        pos = OW'(i);
        hit = 1'b1;
      end
    end
  end

endmodule

@@ rtl/bitmap_block_allocator.sv @@
// Allocate: map words are scanned from word 0 until a free block is found or the last word
// below the block limit is reached; one map word is read from the RAM per cycle.
// Free and test in range: the word is read, then modified and written with the strobe.
// Out of range, or allocate with the used count full: the strobe is set at acceptance.
// A new item may be started in the cycle of the strobe. Reset clears the count and the
// fill mark; map words at or above the fill mark read as free, so no clearing pass is needed.
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS    = BBA_MAX_BLOCKS,
  parameter int MAP_WORD_BITS = BBA_WORD_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [BLK_W-1:0]  in_block_number,
  output logic              out_valid,
  output logic [BLK_W-1:0]  out_result_block,
  output logic              out_bit_value,
  output logic [STAT_W-1:0] out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_total_blocks
);

  // The word width is a power of two.
  localparam int W       = MAP_WORD_BITS;
  localparam int OW      = $clog2(W);
  localparam int WORDS   = (MAX_BLOCKS + W - 1) / W;
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FW      = $clog2(WORDS + 1);
  localparam int LIM_CAP = (MAX_BLOCKS > 32767) ? 32767 : MAX_BLOCKS;

  state_t              state_r, state_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [BLK_W-1:0]    blk_r, blk_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [CFG_W-1:0]    used_r, used_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [CFG_W-1:0]    total_r;
  logic                out_valid_r, out_valid_nxt;
  logic [BLK_W-1:0]    out_block_r, out_block_nxt;
  logic                out_bit_r, out_bit_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;

  logic [CFG_W-1:0]    lim;
  logic                in_range;
  logic                count_full;
  logic [AW-1:0]       in_word;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [W-1:0]        ram_wdata, ram_rdata;
  logic [W-1:0]        cur_word;
  logic [OW-1:0]       scan_pos;
  scan_flags_t         scan_flags;
  logic                last_word;
  logic [OW-1:0]       bit_idx;
  logic                cur_bit;

  // Effective size and range checks for the incoming item.
  always_comb begin
    lim        = (total_r > CFG_W'(LIM_CAP)) ? CFG_W'(LIM_CAP) : total_r;
    in_range   = CFG_W'(in_block_number) < lim;
    count_full = used_r >= lim;
    in_word    = AW'(in_block_number >> OW);
  end

  // Map words at or above the fill mark were never written and read as free.
  always_comb begin
    cur_word  = (FW'(addr_r) < fill_r) ? ram_rdata : '0;
    last_word = scan_flags.last || (addr_r == AW'(WORDS - 1));
    bit_idx   = OW'(W - 1) - blk_r[OW-1:0];
    cur_bit   = cur_word[bit_idx];
  end

  bba_ram #(
    .WIDTH (W),
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bba_word_scan #(
    .W  (W),
    .AW (AW),
    .OW (OW)
  ) u_scan (
    .word      (cur_word),
    .word_addr (addr_r),
    .lim       (lim),
    .pos       (scan_pos),
    .flags     (scan_flags)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_ALLOC) begin
            if (!count_full) begin
              state_nxt = ST_SCAN;
            end
          end else if (in_range) begin
            state_nxt = ST_MODIFY;
          end
        end
      end
      ST_SCAN: begin
        if (scan_flags.found || last_word) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MODIFY: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory accesses, counters and result values.
  always_comb begin
    cmd_nxt        = cmd_r;
    blk_nxt        = blk_r;
    addr_nxt       = addr_r;
    used_nxt       = used_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = 1'b0;
    out_block_nxt  = out_block_r;
    out_bit_nxt    = out_bit_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = cur_word;
    ram_re         = 1'b0;
    ram_raddr      = addr_r + AW'(1);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_cmd;
          blk_nxt = in_block_number;
          if (in_cmd == CMD_ALLOC) begin
            if (count_full) begin
              out_valid_nxt  = 1'b1;
              out_block_nxt  = '0;
              out_bit_nxt    = 1'b0;
              out_status_nxt = STAT_NO_SPACE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              addr_nxt  = '0;
            end
          end else if (!in_range) begin
            out_valid_nxt  = 1'b1;
            out_block_nxt  = in_block_number;
            out_bit_nxt    = 1'b0;
            out_status_nxt = STAT_RANGE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = in_word;
            addr_nxt  = in_word;
          end
        end
      end
      ST_SCAN: begin
        if (scan_flags.found) begin
          // Mark the block used and return its number.
          ram_we         = 1'b1;
          ram_wdata      = cur_word | (W'(1) << (OW'(W - 1) - scan_pos));
          used_nxt       = used_r + CFG_W'(1);
          if (FW'(addr_r) >= fill_r) begin
            fill_nxt = FW'(addr_r) + FW'(1);
          end
          out_valid_nxt  = 1'b1;
          out_block_nxt  = BLK_W'({addr_r, scan_pos});
          out_bit_nxt    = 1'b1;
          out_status_nxt = STAT_OK;
        end else if (last_word) begin
          out_valid_nxt  = 1'b1;
          out_block_nxt  = '0;
          out_bit_nxt    = 1'b0;
          out_status_nxt = STAT_NO_SPACE;
        end else begin
          ram_re   = 1'b1;
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_MODIFY: begin
        out_valid_nxt  = 1'b1;
        out_block_nxt  = blk_r;
        out_status_nxt = STAT_OK;
        if (cmd_r == CMD_FREE) begin
          // Only a set bit is written back and counted.
          out_bit_nxt = 1'b0;
          if (cur_bit) begin
            ram_we    = 1'b1;
            ram_wdata = cur_word & ~(W'(1) << bit_idx);
            if (used_r != '0) begin
              used_nxt = used_r - CFG_W'(1);
            end
          end
        end else begin
          out_bit_nxt = cur_bit;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
      fill_r      <= '0;
      total_r     <= TOTAL_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      if (cfg_valid && cfg_ready) begin
        total_r <= cfg_total_blocks;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    blk_r        <= blk_nxt;
    addr_r       <= addr_nxt;
    out_block_r  <= out_block_nxt;
    out_bit_r    <= out_bit_nxt;
    out_status_r <= out_status_nxt;
  end

  // Ports.
  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_block = out_block_r;
  assign out_bit_value    = out_bit_r;
  assign out_status       = out_status_r;

endmodule

@@ rtl/bba_checker.sv @@
// Port-level checks for the bitmap block allocator and their binding.
module bba_checker
  import bba_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [BLK_W-1:0]  out_result_block,
  input logic              out_bit_value,
  input logic [STAT_W-1:0] out_status,
  input logic              cfg_ready
);

  // An accepted item either keeps the block busy or has its result next cycle.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted item neither busy nor answered");

  // Every busy period ends with a result.
  a_busy_ends_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // A failed allocate returns block zero and a clear bit.
  a_no_space_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_NO_SPACE |-> out_result_block == '0 && !out_bit_value)
    else $error("no-space result with nonzero payload");

  // An out-of-range item never reports a set bit.
  a_range_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_RANGE |-> !out_bit_value)
    else $error("out-of-range result with bit set");

  // Configuration is taken only while idle.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy)
    else $error("configuration ready while busy");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
